// ===== hw/rtl/fcpa_pkg.sv =====
// Shared constants, codes and types of the fixed chunk pool allocator.
package fcpa_pkg;

	localparam int MAX_CHUNKS = 256;
	localparam int ALIGNMENT  = 16;

	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 25;
	localparam int CSZ_W   = 17;
	localparam int DATA_W  = 32;
	localparam int CIDX_W  = 2;
	localparam int EFF_W   = CSZ_W + 1;
	localparam int IDX_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int LINK_W  = IDX_W + 1;
	localparam int ALIGN_W = $clog2(ALIGNMENT);
	localparam int SUM_W   = ((LEN_W > EFF_W) ? LEN_W : EFF_W) + 1;
	localparam int DSR_W   = EFF_W + IDX_W - 1;
	localparam int DIV_W   = (LEN_W > DSR_W) ? LEN_W : DSR_W;
	localparam int CNT_W   = $clog2(IDX_W + 1);

	localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_CHUNKS);

	typedef enum logic [CIDX_W-1:0] {
		CFG_BASE  = 2'd0,
		CFG_LEN   = 2'd1,
		CFG_CSIZE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_FREE    = 2'd1,
		ACT_REBUILD = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_EMPTY   = 3'd1,
		STS_NULL    = 3'd2,
		STS_OUTSIDE = 3'd3,
		STS_OFFBND  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_WALK,
		ST_ALLOC,
		ST_ALLOC_WB,
		ST_FCHK,
		ST_FDIV,
		ST_FPUSH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] dividend;
		logic [EFF_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             exact;
		logic [IDX_W-1:0] quo;
	} div_res_t;

endpackage

// ===== hw/rtl/fcpa_link_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fcpa_link_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/fcpa_div.sv =====
// Restoring divider: chunk offset by chunk size, one quotient bit per cycle.
module fcpa_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fcpa_pkg::div_req_t req,
	output fcpa_pkg::div_res_t res
);

	logic [fcpa_pkg::DIV_W-1:0] rem_q;
	logic [fcpa_pkg::DIV_W-1:0] dsr_q;
	logic [fcpa_pkg::IDX_W-1:0] quo_q;
	logic [fcpa_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       ge;

	assign ge = rem_q >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= fcpa_pkg::CNT_W'(fcpa_pkg::IDX_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= fcpa_pkg::DIV_W'(req.dividend);
			dsr_q <= fcpa_pkg::DIV_W'(req.divisor) << (fcpa_pkg::IDX_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			// subtract when the shifted divisor fits, shift in the quotient bit
			rem_q <= ge ? rem_q - dsr_q : rem_q;
			quo_q <= (quo_q << 1) | fcpa_pkg::IDX_W'(ge);
			dsr_q <= dsr_q >> 1;
		end
	end

	assign res.done  = done_q;
	assign res.exact = (rem_q == '0);
	assign res.quo   = quo_q;

endmodule

// ===== hw/rtl/fixed_chunk_pool_allocator.sv =====
// Fixed chunk pool allocator: LIFO free list of equal chunks kept in a link RAM.
// Steps: allocate reads the head link and forms the chunk address (on an empty list it only
// sets the status), free checks the address, divides the offset in the bit-serial divider and
// pushes the chunk, rebuild writes one link RAM entry per chunk, an unused action goes straight
// to the result. One item at a time: a new request transfers once the result is registered.
// Reset: list empty, geometry zero, registers at 0 / 4096 / 32; link RAM uninitialized.
module fixed_chunk_pool_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        cfg_write,
	input  logic [fcpa_pkg::CIDX_W-1:0] cfg_index,
	input  logic [fcpa_pkg::DATA_W-1:0] cfg_data,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [fcpa_pkg::ADDR_W-1:0] address,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fcpa_pkg::ADDR_W-1:0] chunk_address,
	output logic [2:0]                  status
);

	// configuration registers, applied only at rebuild
	logic [fcpa_pkg::ADDR_W-1:0] base_q;
	logic [fcpa_pkg::LEN_W-1:0]  blen_q;
	logic [fcpa_pkg::CSZ_W-1:0]  csize_q;

	// latched geometry and list head
	logic [fcpa_pkg::ADDR_W-1:0] abase_q;
	logic [fcpa_pkg::EFF_W-1:0]  eff_q;
	logic [fcpa_pkg::LEN_W-1:0]  region_q;
	logic [fcpa_pkg::LINK_W-1:0] head_q;

	fcpa_pkg::state_t state_q, state_d;

	// item registers
	fcpa_pkg::action_t           act_q;
	logic [fcpa_pkg::ADDR_W-1:0] addr_q;

	// rebuild walk
	logic [fcpa_pkg::LEN_W-1:0]  len_q;
	logic [fcpa_pkg::LEN_W-1:0]  acc_q;
	logic [fcpa_pkg::LINK_W-1:0] walk_i_q;
	logic                        walk_go;
	logic [fcpa_pkg::SUM_W-1:0]  acc_next;

	// allocation product and pending result
	logic [fcpa_pkg::IDX_W+fcpa_pkg::EFF_W-1:0] prod_q;
	logic [fcpa_pkg::ADDR_W-1:0] res_addr_q;
	fcpa_pkg::status_t           res_status_q;

	// output register
	logic                        out_valid_q;
	logic [fcpa_pkg::ADDR_W-1:0] out_addr_q;
	fcpa_pkg::status_t           out_status_q;

	// link RAM port signals
	logic                        ram_we;
	logic [fcpa_pkg::IDX_W-1:0]  ram_waddr;
	logic [fcpa_pkg::LINK_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [fcpa_pkg::LINK_W-1:0] ram_rdata;

	fcpa_pkg::div_req_t div_req;
	fcpa_pkg::div_res_t div_res;

	// geometry from the configuration registers
	logic [fcpa_pkg::ADDR_W:0]   abase_w;
	logic [fcpa_pkg::ADDR_W:0]   pad_w;
	logic [fcpa_pkg::ADDR_W:0]   room_w;
	logic [fcpa_pkg::LEN_W-1:0]  len1_w;
	logic [fcpa_pkg::LEN_W-1:0]  len_w;
	logic [fcpa_pkg::CSZ_W-1:0]  req_w;
	logic [fcpa_pkg::EFF_W-1:0]  eff_w;

	// free checks
	logic [fcpa_pkg::ADDR_W-1:0] off_w;
	logic                        free_null;
	logic                        free_out;
	logic                        head_nil;
	logic                        out_free;

	fcpa_link_ram #(
		.DEPTH(fcpa_pkg::MAX_CHUNKS),
		.WIDTH(fcpa_pkg::LINK_W)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_q[fcpa_pkg::IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	fcpa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.res   (div_res)
	);

	// Round the base up, drop the padding from the length, and clip the
	// buffer so it never runs past the top of the address space.
	always_comb begin
		abase_w = ({1'b0, base_q} + (fcpa_pkg::ADDR_W+1)'(fcpa_pkg::ALIGNMENT - 1))
			& ~(fcpa_pkg::ADDR_W+1)'(fcpa_pkg::ALIGNMENT - 1);
		pad_w   = abase_w - {1'b0, base_q};
		len1_w  = (blen_q > pad_w[fcpa_pkg::LEN_W-1:0])
			? blen_q - pad_w[fcpa_pkg::LEN_W-1:0] : '0;
		room_w  = {1'b1, {fcpa_pkg::ADDR_W{1'b0}}} - abase_w;
		if (abase_w[fcpa_pkg::ADDR_W]) begin
			len_w = '0;
		end else if ((fcpa_pkg::ADDR_W+1)'(len1_w) > room_w) begin
			len_w = room_w[fcpa_pkg::LEN_W-1:0];
		end else begin
			len_w = len1_w;
		end
		// a chunk size of zero counts as one
		req_w = (csize_q == '0) ? fcpa_pkg::CSZ_W'(1) : csize_q;
		eff_w = (fcpa_pkg::EFF_W'(req_w) + fcpa_pkg::EFF_W'(fcpa_pkg::ALIGNMENT - 1))
			& ~fcpa_pkg::EFF_W'(fcpa_pkg::ALIGNMENT - 1);
	end

	// Walk pushes chunk i while i is below the chunk limit and the chunk still fits whole into the usable length.
	assign acc_next = fcpa_pkg::SUM_W'(acc_q) + fcpa_pkg::SUM_W'(eff_q);
	assign walk_go  = (walk_i_q < fcpa_pkg::LINK_W'(fcpa_pkg::MAX_CHUNKS))
		&& (acc_next <= fcpa_pkg::SUM_W'(len_q));

	assign off_w     = addr_q - abase_q;
	assign free_null = (addr_q == '0);
	assign free_out  = (addr_q < abase_q) || (off_w >= fcpa_pkg::ADDR_W'(region_q));
	assign head_nil  = (head_q == fcpa_pkg::NIL);
	assign out_free  = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fcpa_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (fcpa_pkg::action_t'(action))
						fcpa_pkg::ACT_ALLOC:   state_d = fcpa_pkg::ST_ALLOC;
						fcpa_pkg::ACT_FREE:    state_d = fcpa_pkg::ST_FCHK;
						fcpa_pkg::ACT_REBUILD: state_d = fcpa_pkg::ST_PREP;
						default:               state_d = fcpa_pkg::ST_DONE;
					endcase
				end
			end
			fcpa_pkg::ST_PREP:     state_d = fcpa_pkg::ST_WALK;
			fcpa_pkg::ST_WALK: begin
				if (!walk_go) begin
					state_d = fcpa_pkg::ST_DONE;
				end
			end
			fcpa_pkg::ST_ALLOC: begin
				state_d = head_nil ? fcpa_pkg::ST_DONE : fcpa_pkg::ST_ALLOC_WB;
			end
			fcpa_pkg::ST_ALLOC_WB: state_d = fcpa_pkg::ST_DONE;
			fcpa_pkg::ST_FCHK: begin
				state_d = (free_null || free_out) ? fcpa_pkg::ST_DONE : fcpa_pkg::ST_FDIV;
			end
			fcpa_pkg::ST_FDIV: begin
				if (div_res.done) begin
					state_d = fcpa_pkg::ST_FPUSH;
				end
			end
			fcpa_pkg::ST_FPUSH:    state_d = fcpa_pkg::ST_DONE;
			fcpa_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = fcpa_pkg::ST_IDLE;
				end
			end
			default:               state_d = fcpa_pkg::ST_IDLE;
		endcase
	end

	// state outputs: handshake, link RAM and divider control
	always_comb begin
		in_ready         = 1'b0;
		ram_we           = 1'b0;
		ram_waddr        = walk_i_q[fcpa_pkg::IDX_W-1:0];
		ram_wdata        = head_q;
		ram_re           = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = off_w[fcpa_pkg::LEN_W-1:0];
		div_req.divisor  = eff_q;
		unique case (state_q)
			fcpa_pkg::ST_IDLE:  in_ready = 1'b1;
			fcpa_pkg::ST_WALK:  ram_we = walk_go;
			fcpa_pkg::ST_ALLOC: ram_re = !head_nil;
			fcpa_pkg::ST_FCHK:  div_req.start = !(free_null || free_out);
			fcpa_pkg::ST_FPUSH: begin
				ram_we    = div_res.exact;
				ram_waddr = div_res.quo;
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			blen_q  <= fcpa_pkg::LEN_W'(4096);
			csize_q <= fcpa_pkg::CSZ_W'(32);
		end else if (cfg_write) begin
			unique case (fcpa_pkg::cfg_idx_t'(cfg_index))
				fcpa_pkg::CFG_BASE:  base_q  <= cfg_data[fcpa_pkg::ADDR_W-1:0];
				fcpa_pkg::CFG_LEN:   blen_q  <= cfg_data[fcpa_pkg::LEN_W-1:0];
				fcpa_pkg::CFG_CSIZE: csize_q <= cfg_data[fcpa_pkg::CSZ_W-1:0];
				default: ;
			endcase
		end
	end

	// control state: FSM, list head, latched geometry, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcpa_pkg::ST_IDLE;
			head_q      <= fcpa_pkg::NIL;
			abase_q     <= '0;
			eff_q       <= '0;
			region_q    <= '0;
			acc_q       <= '0;
			walk_i_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// load a new result when the output register is free, else drop on transfer
			if (state_q == fcpa_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				fcpa_pkg::ST_PREP: begin
					// latch geometry, empty the list, start the walk at chunk 0
					abase_q  <= abase_w[fcpa_pkg::ADDR_W-1:0];
					eff_q    <= eff_w;
					head_q   <= fcpa_pkg::NIL;
					acc_q    <= '0;
					walk_i_q <= '0;
				end
				fcpa_pkg::ST_WALK: begin
					if (walk_go) begin
						head_q   <= walk_i_q;
						acc_q    <= acc_next[fcpa_pkg::LEN_W-1:0];
						walk_i_q <= walk_i_q + 1'b1;
					end else begin
						region_q <= acc_q;
					end
				end
				fcpa_pkg::ST_ALLOC_WB: head_q <= ram_rdata;
				fcpa_pkg::ST_FPUSH: begin
					if (div_res.exact) begin
						head_q <= {1'b0, div_res.quo};
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			fcpa_pkg::ST_IDLE: begin
				if (in_valid) begin
					act_q        <= fcpa_pkg::action_t'(action);
					addr_q       <= address;
					res_addr_q   <= '0;
					res_status_q <= fcpa_pkg::STS_OK;
				end
			end
			fcpa_pkg::ST_PREP: len_q <= len_w;
			fcpa_pkg::ST_ALLOC: begin
				prod_q <= head_q[fcpa_pkg::IDX_W-1:0] * eff_q;
				if (head_nil) begin
					res_status_q <= fcpa_pkg::STS_EMPTY;
				end
			end
			fcpa_pkg::ST_ALLOC_WB: begin
				// address wraps modulo the address space
				res_addr_q <= abase_q + fcpa_pkg::ADDR_W'(prod_q);
			end
			fcpa_pkg::ST_FCHK: begin
				if (free_null) begin
					res_status_q <= fcpa_pkg::STS_NULL;
				end else if (free_out) begin
					res_status_q <= fcpa_pkg::STS_OUTSIDE;
				end
			end
			fcpa_pkg::ST_FPUSH: begin
				if (!div_res.exact) begin
					res_status_q <= fcpa_pkg::STS_OFFBND;
				end
			end
			fcpa_pkg::ST_DONE: begin
				if (out_free) begin
					out_addr_q   <= (act_q == fcpa_pkg::ACT_ALLOC) ? res_addr_q : '0;
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign chunk_address = out_addr_q;
	assign status        = out_status_q;

endmodule

// ===== hw/rtl/fcpa_checker.sv =====
// Port-level checker for the fixed chunk pool allocator, bound to the top level.
module fcpa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [fcpa_pkg::ADDR_W-1:0] chunk_address,
	input logic [2:0]                  status
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chunk_address) && $stable(status))
		else $error("result changed while stalled");

	// only defined status codes leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'(fcpa_pkg::STS_OFFBND))
		else $error("undefined status code");

	// anything but a successful transfer carries a zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'(fcpa_pkg::STS_OK) |-> chunk_address == '0)
		else $error("nonzero address with error status");

	// chunk addresses are always aligned
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chunk_address[fcpa_pkg::ALIGN_W-1:0] == '0)
		else $error("unaligned chunk address");

	// a request transfer with no result pending is never followed by a result in the very next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind fixed_chunk_pool_allocator fcpa_checker u_fcpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.chunk_address(chunk_address),
	.status       (status)
);

// ===== tb/fcpa_pool_checker.sv =====
// Result checker for the fixed chunk pool allocator: tracks the free list and compares results.
module fcpa_pool_checker
	import fcpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        action,
	input  logic [ADDR_W-1:0] address,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [ADDR_W-1:0] chunk_address,
	input  logic [2:0]        status,
	output int                mismatch_count,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           code;
	} pool_reply_t;

	localparam longint unsigned SPACE_TOP  = 64'h1_0000_0000;
	localparam longint unsigned ALIGN_MASK = ALIGNMENT - 1;

	// register copies; they only reach the geometry at a rebuild
	logic [ADDR_W-1:0] pend_base;
	logic [LEN_W-1:0]  pend_len;
	logic [CSZ_W-1:0]  pend_csize;

	logic [LINK_W-1:0] link_mem [MAX_CHUNKS];
	logic [LINK_W-1:0] free_top;
	logic [ADDR_W-1:0] pool_base;
	longint unsigned   unit_bytes;
	longint unsigned   unit_count;

	pool_reply_t awaited[$];
	pool_reply_t oldest;
	int          failures = 0;

	function automatic void flag_mismatch(string msg);
		failures++;
		if (failures <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endfunction

	function automatic void relink_pool();
		longint unsigned raw, rounded, pad, span, req, i;
		raw     = pend_base;
		rounded = (raw + ALIGN_MASK) & ~ALIGN_MASK;
		pad     = rounded - raw;
		span    = (pend_len > pad) ? pend_len - pad : 0;
		if (rounded >= SPACE_TOP) begin
			span = 0;
		end else if (span > SPACE_TOP - rounded) begin
			span = SPACE_TOP - rounded;
		end
		req        = (pend_csize == 0) ? 1 : pend_csize;
		unit_bytes = (req + ALIGN_MASK) & ~ALIGN_MASK;
		unit_count = span / unit_bytes;
		if (unit_count > MAX_CHUNKS)
			unit_count = MAX_CHUNKS;
		pool_base = rounded[ADDR_W-1:0];
		free_top  = NIL;
		for (i = 0; i < unit_count; i++) begin
			link_mem[i] = free_top;
			free_top    = LINK_W'(i);
		end
	endfunction

	function automatic pool_reply_t serve_request(action_t act, logic [ADDR_W-1:0] addr);
		pool_reply_t     reply;
		longint unsigned offset, slot;
		reply.addr = '0;
		reply.code = STS_OK;
		case (act)
		ACT_ALLOC: begin
			if (free_top >= NIL) begin
				reply.code = STS_EMPTY;
			end else begin
				slot       = free_top;
				reply.addr = ADDR_W'(pool_base + slot * unit_bytes);
				free_top   = link_mem[slot];
			end
		end
		ACT_FREE: begin
			offset = 64'(addr) - 64'(pool_base);
			if (addr == '0) begin
				reply.code = STS_NULL;
			end else if (addr < pool_base || offset >= unit_count * unit_bytes) begin
				reply.code = STS_OUTSIDE;
			end else if (offset % unit_bytes != 0) begin
				reply.code = STS_OFFBND;
			end else begin
				slot = offset / unit_bytes;
				if (slot < MAX_CHUNKS) begin
					link_mem[slot] = free_top;
					free_top       = LINK_W'(slot);
				end else begin
					reply.code = STS_OUTSIDE;
				end
			end
		end
		ACT_REBUILD: relink_pool();
		default: ;
		endcase
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_base  = '0;
			pend_len   = LEN_W'(4096);
			pend_csize = CSZ_W'(32);
			foreach (link_mem[i])
				link_mem[i] = NIL;
			free_top   = NIL;
			pool_base  = '0;
			unit_bytes = 0;
			unit_count = 0;
			awaited.delete();
			outstanding <= 0;
		end else begin
			// results first: a transfer here always belongs to an earlier request
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					flag_mismatch($sformatf("result with nothing awaited: chunk_address %h status %0d",
						chunk_address, status));
				end else begin
					oldest = awaited.pop_front();
					if (chunk_address !== oldest.addr)
						flag_mismatch($sformatf("chunk_address expected %h got %h",
							oldest.addr, chunk_address));
					if (status !== oldest.code)
						flag_mismatch($sformatf("status expected %0d got %0d",
							oldest.code, status));
				end
			end
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
				CFG_BASE:  pend_base  = cfg_data;
				CFG_LEN:   pend_len   = cfg_data[LEN_W-1:0];
				CFG_CSIZE: pend_csize = cfg_data[CSZ_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready)
				awaited.push_back(serve_request(action_t'(action), address));
			outstanding    <= awaited.size();
			mismatch_count <= failures;
		end
	end

endmodule

// ===== tb/fixed_chunk_pool_allocator_test.sv =====
// Testbench top for the fixed chunk pool allocator: stimulus, handshake pacing and verdict.
module fixed_chunk_pool_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fcpa_pkg::*;

	// cycles with no transfer on either channel before the run is declared hung;
	// the limit covers a full rebuild plus the longest result stall
	localparam int STALL_LIMIT   = 2000;
	// cycles to watch for stray results once everything has come back
	localparam int SETTLE_CYCLES = 20;
	localparam int BULK_ITEMS    = 110;
	localparam int RANDOM_PHASES = 7;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_write = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [1:0]        action    = '0;
	logic [ADDR_W-1:0] address   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ADDR_W-1:0] chunk_address;
	logic [2:0]        status;
	int                mismatch_count;
	int                outstanding;

	// pool geometry as the stimulus sees it, used only to aim free addresses
	longint unsigned   probe_base = 0;
	longint unsigned   probe_unit = 32;
	// chunks handed out by the block and not yet given back
	logic [ADDR_W-1:0] held_chunks[$];
	// when set, neither side idles: no random gaps on either channel for the whole phase
	bit                steady = 1'b0;
	int                quiet_cycles = 0;

	fixed_chunk_pool_allocator dut (.*);

	fcpa_pool_checker checker_i (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side: hold ready for a while, then stall for a gap.
	initial begin : result_sink
		int hold, stall;
		forever begin
			hold = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (hold) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Collect allocated chunks so that frees can return a chunk actually in use.
	// Free and rebuild results carry address zero, so a nonzero OK result is an allocation.
	always @(posedge clk) begin
		if (out_valid && out_ready && status == STS_OK && chunk_address != '0) begin
			held_chunks.push_back(chunk_address);
			if (held_chunks.size() > 512)
				void'(held_chunks.pop_front());
		end
	end

	// Hang detector: restart the count on every transfer.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one request and hold it until the transfer. Valid stays high
	// across back-to-back requests; it drops only when a gap comes first or in settle_pool.
	task automatic send_request(action_t act, logic [ADDR_W-1:0] addr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		address  <= addr;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every awaited result has been transferred.
	// Every request yields a result, so an empty queue means the block is idle.
	task automatic settle_pool();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic program_pool(logic [31:0] base, logic [31:0] len, logic [31:0] csize);
		settle_pool();
		write_reg(CFG_BASE, base);
		write_reg(CFG_LEN, len);
		write_reg(CFG_CSIZE, csize);
		cfg_write <= 1'b0;
		probe_base = (64'(base) + ALIGNMENT - 1) & ~64'(ALIGNMENT - 1);
		probe_unit = (64'((csize == 0) ? 1 : csize) + ALIGNMENT - 1) & ~64'(ALIGNMENT - 1);
	endtask

	// Free addresses: chunks in use most often, then chunk starts across and past the
	// region (double frees, tail), misaligned ones, null, below the base and noise.
	function automatic logic [ADDR_W-1:0] pick_free_address();
		int                r, k;
		logic [ADDR_W-1:0] addr;
		r = $urandom_range(0, 99);
		if (r < 45 && held_chunks.size() > 0) begin
			k    = $urandom_range(0, held_chunks.size() - 1);
			addr = held_chunks[k];
			held_chunks.delete(k);
		end else if (r < 62) begin
			addr = ADDR_W'(probe_base + $urandom_range(0, 300) * probe_unit);
		end else if (r < 74) begin
			addr = ADDR_W'(probe_base + $urandom_range(0, 40) * probe_unit
				+ $urandom_range(1, probe_unit - 1));
		end else if (r < 80) begin
			addr = '0;
		end else if (r < 86) begin
			addr = ADDR_W'(probe_base - $urandom_range(1, 64));
		end else begin
			addr = $urandom();
		end
		return addr;
	endfunction

	// Random traffic; the allocate share changes every 20 requests so the list
	// drains to empty and fills back up.
	task automatic run_mix(int count);
		int bias, r, n;
		for (n = 0; n < count; n++) begin
			if (n % 20 == 0) begin
				case ($urandom_range(0, 2))
				0: bias = 20;
				1: bias = 50;
				default: bias = 85;
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < bias) begin
				send_request(ACT_ALLOC, $urandom());
			end else if (r < 95) begin
				send_request(ACT_FREE, pick_free_address());
			end else if (r < 97) begin
				held_chunks.delete();
				send_request(ACT_REBUILD, $urandom());
			end else begin
				send_request(ACT_NONE, $urandom());
			end
		end
	endtask

	task automatic run_phase(logic [31:0] base, logic [31:0] len, logic [31:0] csize);
		steady = ($urandom_range(0, 3) == 0);
		program_pool(base, len, csize);
		// new registers must not show until the rebuild: these still see the old pool
		send_request(ACT_ALLOC, $urandom());
		send_request(ACT_FREE, pick_free_address());
		held_chunks.delete();
		send_request(ACT_REBUILD, $urandom());
		run_mix(BULK_ITEMS);
	endtask

	task automatic run_random_phase();
		logic [31:0] len, csize;
		case ($urandom_range(0, 2))
		0: len = $urandom_range(0, 4096);
		1: len = $urandom_range(0, 65536);
		default: len = $urandom_range(0, 16777216);
		endcase
		csize = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(0, 65536);
		run_phase($urandom(), len, csize);
	endtask

	initial begin : stimulus
		int p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers (base 0, 4096 bytes, 32 byte chunks: 128 chunks), no geometry yet
		send_request(ACT_ALLOC, 32'h0);          // nothing built: pool empty
		send_request(ACT_FREE, 32'h0000_0040);   // no region yet: outside
		send_request(ACT_FREE, 32'h0);           // null
		send_request(ACT_NONE, 32'hFFFF_FFFF);   // unused code does nothing
		send_request(ACT_REBUILD, 32'h0);
		send_request(ACT_ALLOC, 32'hFFFF_FFFF);  // highest chunk first
		send_request(ACT_ALLOC, 32'h0);
		send_request(ACT_FREE, 32'h0000_0FE0);
		send_request(ACT_ALLOC, 32'h0);          // LIFO: the chunk just freed
		send_request(ACT_FREE, 32'h0000_0FC8);   // off a chunk start
		send_request(ACT_FREE, 32'h0000_1000);   // one past the end
		send_request(ACT_FREE, 32'hFFFF_FFFF);
		send_request(ACT_FREE, 32'h0);           // null even with a chunk at zero
		send_request(ACT_FREE, 32'h0000_0FC0);
		send_request(ACT_FREE, 32'h0000_0FC0);   // double free goes on the list again
		send_request(ACT_ALLOC, 32'h0);
		send_request(ACT_ALLOC, 32'h0);
		send_request(ACT_FREE, 32'h0000_0FE0);
		send_request(ACT_REBUILD, 32'hFFFF_FFFF);

		// Geometry corners
		run_phase(32'h0000_1003, 32'd100, 32'd0);           // padding, size zero: 5 chunks
		run_phase(32'hFFFF_FFF9, 32'd4096, 32'd16);         // base rounds past the top
		run_phase(32'hFFFF_F000, 32'd16777216, 32'd1);      // cut at the top, saturated
		run_phase(32'h0000_0000, 32'd16777216, 32'd65536);  // largest chunk and length
		run_phase(32'h0000_0007, 32'd5, 32'd32);            // padding exceeds length
		run_phase(32'h0000_0000, 32'd0, 32'd17);            // empty buffer
		run_phase(32'h8000_0000, 32'd1000, 32'd48);         // short tail past the chunks
		run_phase(32'h7FFF_FFF1, 32'd16777216, 32'd65535);  // unaligned base, big chunks
		run_phase(32'hFFFF_FF00, 32'd2048, 32'd1);          // chunks run up to the top

		for (p = 0; p < RANDOM_PHASES; p++)
			run_random_phase();

		settle_pool();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/fcpa_pkg.sv
hw/rtl/fcpa_link_ram.sv
hw/rtl/fcpa_div.sv
hw/rtl/fixed_chunk_pool_allocator.sv
hw/rtl/fcpa_checker.sv
tb/fcpa_pool_checker.sv
tb/fixed_chunk_pool_allocator_test.sv
